// ----- rtl/ffiw_pkg.sv -----
// ---------------------------------------------------------------------------
// ffiw_pkg: shared types and constants of the interpolating wavetable filter
// Item codes, field layout of the stream words, arithmetic widths, and the
// command and status groups between the controller and the datapath.
// ---------------------------------------------------------------------------
package ffiw_pkg;

	// item codes carried in the input tuser
	typedef enum logic [1:0] {
		OP_WR_SAMPLE = 2'd0,
		OP_WR_COEF   = 2'd1,
		OP_SWAP      = 2'd2,
		OP_COMPUTE   = 2'd3
	} op_t;

	// input stream layout
	localparam int IN_DATA_W  = 56;
	localparam int IN_USER_W  = 2;
	localparam int ADDR_W     = 11;
	localparam int TAP_W      = 6;
	localparam int VAL_W      = 16;
	localparam int RATIO_W    = 16;
	localparam int ADDR_LSB   = 0;
	localparam int TAP_LSB    = ADDR_LSB + ADDR_W;
	localparam int VAL_LSB    = TAP_LSB + TAP_W;
	localparam int RATIO_LSB  = VAL_LSB + VAL_W;

	// output stream layout
	localparam int OUT_DATA_W = 16;

	// arithmetic widths, sized for the largest tap count (64 folded taps)
	localparam int PAIR_W     = VAL_W + 1;
	localparam int DIFF_W     = VAL_W + 2;
	localparam int PROD0_W    = VAL_W + PAIR_W;
	localparam int PRODD_W    = VAL_W + DIFF_W;
	localparam int ACC0_W     = 40;
	localparam int ACC1_W     = 41;
	localparam int SPLIT_W    = 21;
	localparam int MUL_W      = 37;
	localparam int TOT_W      = 59;
	localparam int RND_SHIFT  = 31;
	localparam int SH_W       = TOT_W - RND_SHIFT;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic reduce;
		logic wr_sample;
		logic wr_coef;
		logic swap;
		logic start;
		logic issue;
		logic first;
		logic shift_prev;
		logic pair_en;
		logic centre;
		logic mul_en;
		logic acc_en;
		logic fin1;
		logic fin2;
		logic fin3;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic addr_big;
		op_t  op;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/ffiw_ctrl.sv -----
// ---------------------------------------------------------------------------
// ffiw_ctrl: sequencing of the interpolating wavetable filter
// Accepts items, folds the address into the table, dispatches writes and
// bank swaps, and walks the folded taps of a compute through the datapath.
// ---------------------------------------------------------------------------
module ffiw_ctrl #(
	parameter int TAPS = 31
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ffiw_pkg::sts_t  sts,
	output ffiw_pkg::cmd_t  cmd
);
	import ffiw_pkg::*;

	localparam int HALF_TAPS = TAPS / 2;
	localparam int K_W       = $clog2(HALF_TAPS + 2);
	localparam logic [K_W-1:0] K_LAST = K_W'(HALF_TAPS + 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_EXEC  = 9'b000000010,
		ST_RUN   = 9'b000000100,
		ST_DRAIN = 9'b000001000,
		ST_FIN1  = 9'b000010000,
		ST_FIN2  = 9'b000100000,
		ST_FIN3  = 9'b001000000,
		ST_FIN4  = 9'b010000000,
		ST_SPARE = 9'b100000000
	} state_t;

	state_t         state_q, state_d;
	logic [K_W-1:0] k_q;
	logic           iss_s1, first_s1, centre_s1, mul_v_s2, acc_v_s3;

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.addr_big) begin
					cmd.reduce = 1'b1;
				end else begin
					case (sts.op)
						OP_WR_SAMPLE: begin
							cmd.wr_sample = 1'b1;
							state_d       = ST_IDLE;
						end
						OP_WR_COEF: begin
							cmd.wr_coef = 1'b1;
							state_d     = ST_IDLE;
						end
						OP_SWAP: begin
							cmd.swap = 1'b1;
							state_d  = ST_IDLE;
						end
						OP_COMPUTE: begin
							cmd.start = 1'b1;
							state_d   = ST_RUN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				cmd.first = (k_q == '0);
				if (k_q == K_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last accumulate happens at this edge when only it is pending
				if (!iss_s1 && !mul_v_s2) begin
					state_d = ST_FIN1;
				end
			end
			ST_FIN1: begin
				cmd.fin1 = 1'b1;
				state_d  = ST_FIN2;
			end
			ST_FIN2: begin
				cmd.fin2 = 1'b1;
				state_d  = ST_FIN3;
			end
			ST_FIN3: begin
				cmd.fin3 = 1'b1;
				state_d  = ST_FIN4;
			end
			ST_FIN4: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// tap pipeline enables
		cmd.shift_prev = iss_s1;
		cmd.pair_en    = iss_s1 & ~first_s1;
		cmd.centre     = centre_s1;
		cmd.mul_en     = mul_v_s2;
		cmd.acc_en     = acc_v_s3;
	end

	// state, tap counter and pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			iss_s1    <= 1'b0;
			first_s1  <= 1'b0;
			centre_s1 <= 1'b0;
			mul_v_s2  <= 1'b0;
			acc_v_s3  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				k_q <= '0;
			end else if (cmd.issue) begin
				k_q <= k_q + 1'b1;
			end
			iss_s1    <= cmd.issue;
			first_s1  <= cmd.first;
			centre_s1 <= cmd.issue && (k_q == K_LAST);
			mul_v_s2  <= cmd.pair_en;
			acc_v_s3  <= mul_v_s2;
		end
	end

endmodule

// ----- rtl/ffiw_datapath.sv -----
// ---------------------------------------------------------------------------
// ffiw_datapath: tables, folded tap arithmetic and result register
// Holds the sample table, both coefficient banks and the active bank bit,
// runs one folded tap per cycle through add, multiply and accumulate stages,
// then blends, rounds and saturates into the output register.
// ---------------------------------------------------------------------------
module ffiw_datapath #(
	parameter int TAPS        = 31,
	parameter int TABLE_DEPTH = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [ffiw_pkg::IN_DATA_W-1:0]     in_data,
	input  logic [ffiw_pkg::IN_USER_W-1:0]     in_user,
	input  ffiw_pkg::cmd_t                     cmd,
	output ffiw_pkg::sts_t                     sts,
	output logic [ffiw_pkg::OUT_DATA_W-1:0]    out_data,
	output logic                               out_user,
	output logic                               out_valid,
	input  logic                               out_ready
);
	import ffiw_pkg::*;

	localparam int HALF_TAPS = TAPS / 2;
	localparam int BANK_LEN  = HALF_TAPS + 1;
	localparam int IDX_W     = $clog2(TABLE_DEPTH);
	localparam int CIDX_W    = $clog2(BANK_LEN);
	localparam int CA_W      = $clog2(2 * BANK_LEN);
	localparam int CMP_W     = 17;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [IDX_W:0]   DEPTH_P   = (IDX_W + 1)'(TABLE_DEPTH);
	localparam logic [IDX_W:0]   LO_OFFSET = (IDX_W + 1)'(TABLE_DEPTH - (TAPS - 1));
	localparam logic [CA_W-1:0]  BANK1_BASE = CA_W'(BANK_LEN);
	localparam logic [TOT_W-1:0] RND_BIAS  = TOT_W'(64'd1 << (RND_SHIFT - 1));

	// storage
	logic signed [VAL_W-1:0] smem [TABLE_DEPTH];
	logic signed [VAL_W-1:0] cmem [2 * BANK_LEN];

	// latched item
	op_t                     op_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [TAP_W-1:0]        tap_q;
	logic signed [VAL_W-1:0] value_q;
	logic [RATIO_W-1:0]      ratio_q;
	logic                    bank_q;

	// walk pointers
	logic [IDX_W-1:0]  lo_q, hi_q, a_idx, lo_init, hi_init;
	logic [IDX_W:0]    lo_sum;
	logic [CIDX_W-1:0] cidx_q;
	logic [CA_W-1:0]   crd_addr, cwr_addr;

	// tap pipeline
	logic signed [VAL_W-1:0]   rlo_s1, rhi_s1, coef_s1, plo_q, phi_q;
	logic signed [PAIR_W-1:0]  pair0, pair1;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PAIR_W-1:0]  pair0_s2;
	logic signed [DIFF_W-1:0]  diff_s2;
	logic signed [VAL_W-1:0]   coef_s2;
	logic signed [PROD0_W-1:0] prod0_s3;
	logic signed [PRODD_W-1:0] prodd_s3;
	logic signed [ACC0_W-1:0]  a0_q;
	logic signed [ACC1_W-1:0]  a1_q;

	// blend and round
	logic [MUL_W-1:0]        mlo_q;
	logic signed [MUL_W-1:0] mhi_q;
	logic signed [TOT_W-1:0] tot_q;
	logic signed [SH_W-1:0]  sh;
	logic signed [VAL_W-1:0] sat;

	// output register
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_bank_q, out_valid_q;

	// status
	assign sts.addr_big = (CMP_W'(addr_q) >= CMP_W'(TABLE_DEPTH));
	assign sts.op       = op_q;
	assign sts.out_free = ~out_valid_q | out_ready;

	// start pointers: newest sample plus one on the high side, oldest on the low side
	always_comb begin
		a_idx   = IDX_W'(addr_q);
		lo_sum  = {1'b0, a_idx} + LO_OFFSET;
		lo_init = (lo_sum >= DEPTH_P) ? IDX_W'(lo_sum - DEPTH_P) : IDX_W'(lo_sum);
		hi_init = (a_idx == LAST_IDX) ? '0 : a_idx + 1'b1;
	end

	// coefficient addresses in the active and inactive banks
	assign crd_addr = bank_q ? BANK1_BASE + CA_W'(cidx_q) : CA_W'(cidx_q);
	assign cwr_addr = bank_q ? CA_W'(tap_q) : BANK1_BASE + CA_W'(tap_q);

	// folded pair and its step toward the next position
	always_comb begin
		if (cmd.centre) begin
			pair0 = PAIR_W'(plo_q);
			pair1 = PAIR_W'(rlo_s1);
		end else begin
			pair0 = PAIR_W'(plo_q) + PAIR_W'(rhi_s1);
			pair1 = PAIR_W'(rlo_s1) + PAIR_W'(phi_q);
		end
		diff = DIFF_W'(pair1) - DIFF_W'(pair0);
	end

	// round half up and saturate
	always_comb begin
		sh = $signed(tot_q[TOT_W-1:RND_SHIFT]);
		if (sh > SH_W'(32767)) begin
			sat = 16'sh7FFF;
		end else if (sh < -SH_W'(32768)) begin
			sat = -16'sh8000;
		end else begin
			sat = VAL_W'(sh);
		end
	end

	// sample table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.wr_sample) begin
			smem[a_idx] <= value_q;
		end
		if (cmd.issue) begin
			rlo_s1 <= smem[lo_q];
			rhi_s1 <= smem[hi_q];
		end
	end

	// coefficient banks: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_coef && (7'(tap_q) < 7'(BANK_LEN))) begin
			cmem[cwr_addr] <= value_q;
		end
		if (cmd.issue && !cmd.first) begin
			coef_s1 <= cmem[crd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(in_user);
			addr_q  <= in_data[ADDR_LSB +: ADDR_W];
			tap_q   <= in_data[TAP_LSB +: TAP_W];
			value_q <= $signed(in_data[VAL_LSB +: VAL_W]);
			ratio_q <= in_data[RATIO_LSB +: RATIO_W];
		end else if (cmd.reduce) begin
			addr_q <= addr_q - ADDR_W'(TABLE_DEPTH);
		end
		// walk the low side up and the high side down, both wrapping
		if (cmd.start) begin
			lo_q   <= lo_init;
			hi_q   <= hi_init;
			cidx_q <= '0;
		end else if (cmd.issue) begin
			lo_q <= (lo_q == LAST_IDX) ? '0 : lo_q + 1'b1;
			hi_q <= (hi_q == '0) ? LAST_IDX : hi_q - 1'b1;
			if (!cmd.first) begin
				cidx_q <= cidx_q + 1'b1;
			end
		end
		if (cmd.shift_prev) begin
			plo_q <= rlo_s1;
			phi_q <= rhi_s1;
		end
		if (cmd.pair_en) begin
			pair0_s2 <= pair0;
			diff_s2  <= diff;
			coef_s2  <= coef_s1;
		end
		if (cmd.mul_en) begin
			prod0_s3 <= coef_s2 * pair0_s2;
			prodd_s3 <= coef_s2 * diff_s2;
		end
		// two accumulators: the filter at pos, and its step to pos+1
		if (cmd.start) begin
			a0_q <= '0;
			a1_q <= '0;
		end else if (cmd.acc_en) begin
			a0_q <= a0_q + ACC0_W'(prod0_s3);
			a1_q <= a1_q + ACC1_W'(prodd_s3);
		end
		// ratio times the step, split in low and high halves
		if (cmd.fin1) begin
			mlo_q <= MUL_W'(ratio_q) * MUL_W'(a1_q[SPLIT_W-1:0]);
		end
		if (cmd.fin2) begin
			mhi_q <= $signed({1'b0, ratio_q}) * $signed(a1_q[ACC1_W-1:SPLIT_W]);
			tot_q <= (TOT_W'(a0_q) <<< RATIO_W) + $signed(TOT_W'(mlo_q))
				+ $signed(RND_BIAS);
		end
		if (cmd.fin3) begin
			tot_q <= tot_q + (TOT_W'(mhi_q) <<< SPLIT_W);
		end
		if (cmd.out_load) begin
			out_data_q <= sat;
			out_bank_q <= bank_q;
		end
	end

	// active bank and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.swap) begin
				bank_q <= ~bank_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_data  = out_data_q;
	assign out_user  = out_bank_q;
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/folded_fir_interpolating_wavetable.sv -----
// ---------------------------------------------------------------------------
// folded_fir_interpolating_wavetable: folded FIR over a circular wavetable
// Symmetric odd-length FIR read from a wrapping sample table, two swappable
// coefficient banks, and linear blending toward the next table position.
//
//   channel  dir  transfer carries
//   s_axis   in   tuser: opcode; tdata: address, tap_index, value, ratio
//   m_axis   out  tdata: filtered_sample; tuser: bank_used
//
// A compute walks the folded taps through the one tap multiply-accumulate path
// fed by the two read ports of the sample table. Writes and bank swaps go
// through the accept and execute states. An address at or above TABLE_DEPTH
// is folded by repeated subtraction of TABLE_DEPTH before the item executes.
// Reset clears the active bank to zero; table contents stay undefined.
// A result waiting on m_axis does not block new items; a compute holds in
// its last cycle only while the previous result is still not taken.
// ---------------------------------------------------------------------------
module folded_fir_interpolating_wavetable #(
	parameter int TAPS        = 31,
	parameter int TABLE_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // address[10:0], tap_index[16:11], value[32:17], ratio[48:33]
	input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // filtered_sample[15:0]
	output logic        m_axis_tuser   // bank_used[0]
);
	import ffiw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	ffiw_ctrl #(
		.TAPS(TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// tables and arithmetic
	ffiw_datapath #(
		.TAPS        (TAPS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

endmodule

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: stream-level check of the interpolating wavetable filter
// Drives write, coefficient, swap and compute transfers with random idle
// bursts on both sides and one long output hold-off. A scoreboard keeps its
// own copy of the sample table, both coefficient banks and the active bank,
// works out the blended filter output of every accepted compute, and checks
// each output transfer against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module testbench;
	import ffiw_pkg::*;

	localparam int TAPS         = 31;
	localparam int HALF         = TAPS / 2;
	localparam int BANK_LEN     = TAPS / 2 + 1;
	localparam int DEPTH        = 2048;
	localparam int TOTAL_ITEMS  = 1100;
	localparam int CALM_ITEMS   = 100;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 80;
	localparam int MAX_PRINTS   = 100;

	// one predicted output transfer
	typedef struct {
		bit signed [15:0] filtered;
		bit               bank;
	} blend_t;

	// mirror of the filter state and queue of predicted outputs
	class blend_scoreboard;
		bit signed [15:0] samples [DEPTH];
		bit signed [15:0] coefs [2][BANK_LEN];
		bit               active;
		blend_t           pending_blends[$];
		int               failures;

		function new();
			active   = 1'b0;
			failures = 0;
		endfunction

		function void report(string msg);
			if (failures < MAX_PRINTS)
				$display("ERROR: %0t %s", $realtime, msg);
			failures++;
		endfunction

		// folded fir with its newest sample at the given position, scaled by 2^30
		function longint fir_at(bit [10:0] newest);
			bit [10:0] hi;
			bit [10:0] lo;
			longint    acc;
			hi  = newest;
			lo  = newest - 11'(TAPS - 1);
			acc = 0;
			for (int i = 0; i < HALF; i++) begin
				acc += longint'(coefs[active][i]) *
					(longint'(samples[lo]) + longint'(samples[hi]));
				lo++;
				hi--;
			end
			acc += longint'(coefs[active][HALF]) * longint'(samples[lo]);
			return acc;
		endfunction

		// blend toward the next position, round half up, saturate to q1.15
		function blend_t blend_at(bit [10:0] pos, bit [15:0] ratio);
			longint f0;
			longint f1;
			longint sum;
			longint rounded;
			blend_t b;
			f0      = fir_at(pos);
			f1      = fir_at(pos + 11'd1);
			sum     = longint'(65536 - int'(ratio)) * f0 + longint'(ratio) * f1;
			rounded = (sum + (longint'(1) <<< 30)) >>> 31;
			if (rounded > 32767)
				rounded = 32767;
			if (rounded < -32768)
				rounded = -32768;
			b.filtered = 16'(rounded);
			b.bank     = active;
			return b;
		endfunction

		// an input transfer was accepted
		function void note_input(op_t op, bit [10:0] addr, bit [5:0] tap,
			bit signed [15:0] val, bit [15:0] ratio);
			case (op)
				OP_WR_SAMPLE: samples[addr] = val;
				OP_WR_COEF: begin
					if (tap < BANK_LEN)
						coefs[!active][tap] = val;
				end
				OP_SWAP: active = !active;
				OP_COMPUTE: pending_blends.push_back(blend_at(addr, ratio));
			endcase
		endfunction

		// an output transfer was accepted
		function void check_result(bit signed [15:0] got, bit got_bank);
			blend_t want;
			if (pending_blends.size() == 0) begin
				report($sformatf("unexpected output sample=%0d bank=%0d", got, got_bank));
				return;
			end
			want = pending_blends.pop_front();
			if (got !== want.filtered || got_bank !== want.bank)
				report($sformatf("output sample=%0d bank=%0d, predicted sample=%0d bank=%0d",
					got, got_bank, want.filtered, want.bank));
		endfunction

		function int waiting();
			return pending_blends.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata  = '0;   // address, tap_index, value, ratio
	logic [1:0]  s_axis_tuser  = '0;   // opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;          // filtered_sample
	logic        m_axis_tuser;          // bank_used

	blend_scoreboard sb = new();

	bit        sample_set [DEPTH];
	bit [10:0] centres[$];
	int        sent      = 0;
	int        idle_odds = 0;
	bit        calm      = 1'b0;
	bit        hold_now  = 1'b0;
	bit        holding   = 1'b0;
	bit        hold_done = 1'b0;

	folded_fir_interpolating_wavetable u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard limit on run length
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// output side: random stalls, one long hold-off, none near the end
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_now && !hold_done) begin
				holding = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding   = 1'b0;
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// one input transfer, with an optional idle burst ahead of it
	task automatic send_item(op_t op, bit [10:0] addr, bit [5:0] tap,
		bit [15:0] val, bit [15:0] ratio);
		int gap;
		gap = 0;
		if (sent % 64 == 0)
			idle_odds = $urandom_range(0, 1) ? 3 : 0;
		if (!calm && !holding && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
			gap = $urandom_range(1, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tuser  <= op;
		s_axis_tdata  <= {7'd0, ratio, val, tap, addr};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_input(op, addr, tap, val, ratio);
		sent++;
	endtask

	function automatic bit [15:0] random_sample();
		case ($urandom_range(0, 19))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_sample(bit [10:0] addr, bit [15:0] val);
		sample_set[addr] = 1'b1;
		send_item(OP_WR_SAMPLE, addr, 6'($urandom), val, 16'($urandom));
	endtask

	// write every position that a compute at this newest position reads
	task automatic fill_window(bit [10:0] newest, bit full_scale);
		for (int k = 0; k < TAPS + 1; k++)
			write_sample(newest - 11'(TAPS - 1) + 11'(k),
				full_scale ? 16'h7FFF : random_sample());
		centres.push_back(newest);
	endtask

	function automatic bit window_ok(bit [10:0] newest);
		for (int k = 0; k < TAPS + 1; k++)
			if (!sample_set[newest - 11'(TAPS - 1) + 11'(k)])
				return 1'b0;
		return 1'b1;
	endfunction

	// compute at a position whose whole read window has been written
	task automatic random_compute();
		bit [10:0] pos;
		bit [15:0] ratio;
		int        tries;
		pos   = 11'($urandom);
		tries = 0;
		while (!window_ok(pos) && tries < 16) begin
			pos = 11'($urandom);
			tries++;
		end
		if (!window_ok(pos))
			pos = centres[$urandom_range(0, centres.size() - 1)];
		case ($urandom_range(0, 19))
			0, 1:    ratio = 16'd0;
			2:       ratio = 16'hFFFF;
			default: ratio = 16'($urandom);
		endcase
		send_item(OP_COMPUTE, pos, 6'($urandom), 16'($urandom), ratio);
	endtask

	task automatic random_coef();
		bit [5:0]  tap;
		bit [15:0] val;
		tap = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, HALF))
			: 6'($urandom_range(BANK_LEN, 63));
		case ($urandom_range(0, 19))
			0:             val = 16'h7FFF;
			1:             val = 16'h8000;
			2, 3, 4, 5, 6: val = 16'($urandom);
			default:       val = 16'($urandom_range(0, 8191) - 4096);
		endcase
		send_item(OP_WR_COEF, 11'($urandom), tap, val, 16'($urandom));
	endtask

	// main stimulus
	initial begin
		int pick;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bank 1 all full-scale positive, bank 0 all full-scale negative
		for (int t = 0; t < BANK_LEN; t++)
			send_item(OP_WR_COEF, 11'($urandom), 6'(t), 16'h7FFF, 16'($urandom));
		send_item(OP_SWAP, 11'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
		for (int t = 0; t < BANK_LEN; t++)
			send_item(OP_WR_COEF, 11'($urandom), 6'(t), 16'h8000, 16'($urandom));
		// taps past the centre are dropped
		send_item(OP_WR_COEF, 11'd0, 6'd16, 16'h0001, 16'h0000);
		send_item(OP_WR_COEF, 11'h7FF, 6'd63, 16'h0001, 16'hFFFF);

		// window across the table wrap, full-scale samples
		fill_window(11'h7FF, 1'b1);
		write_sample(11'd1, 16'h7FFF);
		centres.push_back(11'd0);
		// positive saturation on bank 1, at both ratio extremes
		send_item(OP_COMPUTE, 11'h7FF, 6'($urandom), 16'($urandom), 16'h0000);
		send_item(OP_COMPUTE, 11'd0, 6'($urandom), 16'($urandom), 16'hFFFF);
		// negative saturation on bank 0
		send_item(OP_SWAP, 11'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
		send_item(OP_COMPUTE, 11'h7FF, 6'($urandom), 16'($urandom), 16'h8000);
		write_sample(11'd0, 16'h8000);
		send_item(OP_COMPUTE, 11'd0, 6'($urandom), 16'($urandom), 16'h0000);

		// random mix, with computes over written windows as the commonest item
		fill_window(11'($urandom), 1'b0);
		while (sent < TOTAL_ITEMS) begin
			if (sent >= TOTAL_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if (sent >= HOLD_AT)
				hold_now = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 1)
				fill_window(11'($urandom), 1'b0);
			else if (pick < 42)
				random_compute();
			else if (pick < 70)
				write_sample(11'($urandom), random_sample());
			else if (pick < 93)
				random_coef();
			else
				send_item(OP_SWAP, 11'($urandom), 6'($urandom), 16'($urandom),
					16'($urandom));
		end
		s_axis_tvalid <= 1'b0;

		// drain outstanding outputs, then keep watching for stray outputs
		while (sb.waiting() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ffiw_pkg.sv
rtl/ffiw_ctrl.sv
rtl/ffiw_datapath.sv
rtl/folded_fir_interpolating_wavetable.sv
verif/testbench.sv
